>>> hw/rtl/ncr_pkg.sv
// ----------------------------------------------------------------------------
// ncr_pkg: shared types and constants of the route compute core
// field widths, coordinate type, operation, algorithm and register codes
// ----------------------------------------------------------------------------
`default_nettype none

package ncr_pkg;

  localparam int ID_W       = 6;
  localparam int COL_W      = 7;
  localparam int PORT_W     = 3;
  localparam int WEIGHT_W   = 8;
  localparam int FREE_W     = 4;
  localparam int MASK_W     = 64;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 3;

  // router position split out of an identifier
  typedef struct packed {
    logic [ID_W-1:0] x;
    logic [ID_W-1:0] y;
  } coord_t;

  typedef enum logic [1:0] {
    OP_ROUTE = 2'd0,
    OP_WRITE = 2'd1,
    OP_FREE  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ALG_TABLE            = 3'd0,
    ALG_XY               = 3'd1,
    ALG_RANDOM           = 3'd2,
    ALG_ADAPT_RANDOM     = 3'd3,
    ALG_WEST_FIRST       = 3'd4,
    ALG_ADAPT_WEST_FIRST = 3'd5
  } alg_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALGORITHM = 3'd0,
    CFG_MY_ID     = 3'd1,
    CFG_COLUMNS   = 3'd2,
    CFG_EAST      = 3'd3,
    CFG_WEST      = 3'd4,
    CFG_NORTH     = 3'd5,
    CFG_SOUTH     = 3'd6
  } cfg_idx_e;

  localparam logic [COL_W-1:0]  COLS_RESET  = 7'd8;
  localparam logic [PORT_W-1:0] EAST_RESET  = 3'd0;
  localparam logic [PORT_W-1:0] WEST_RESET  = 3'd1;
  localparam logic [PORT_W-1:0] NORTH_RESET = 3'd2;
  localparam logic [PORT_W-1:0] SOUTH_RESET = 3'd3;

endpackage

`default_nettype wire

>>> hw/rtl/ncr_route_mem.sv
// ----------------------------------------------------------------------------
// ncr_route_mem: route table storage
// mask and weight memory with one write and one registered read port,
// per-entry valid flags cleared by reset
// ----------------------------------------------------------------------------
`default_nettype none

module ncr_route_mem import ncr_pkg::*; #(
  parameter int DEPTH   = 8,
  parameter int MASK_BITS = 64,
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 wr_en_i,
  input  wire logic [AW-1:0]        wr_addr_i,
  input  wire logic [MASK_BITS-1:0] wr_mask_i,
  input  wire logic [WEIGHT_W-1:0]  wr_weight_i,
  input  wire logic                 rd_en_i,
  input  wire logic [AW-1:0]        rd_addr_i,
  output logic                      rd_valid_o,
  output logic [MASK_BITS-1:0]      rd_mask_o,
  output logic [WEIGHT_W-1:0]       rd_weight_o
);

  logic [MASK_BITS-1:0] mask_mem   [DEPTH];
  logic [WEIGHT_W-1:0]  weight_mem [DEPTH];
  logic [DEPTH-1:0]     valid_q;
  logic                 rd_valid_q;
  logic [MASK_BITS-1:0] rd_mask_q;
  logic [WEIGHT_W-1:0]  rd_weight_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mask_mem[wr_addr_i]   <= wr_mask_i;
      weight_mem[wr_addr_i] <= wr_weight_i;
    end
    if (rd_en_i) begin
      rd_mask_q   <= mask_mem[rd_addr_i];
      rd_weight_q <= weight_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_valid_o  = rd_valid_q;
  assign rd_mask_o   = rd_mask_q;
  assign rd_weight_o = rd_weight_q;

endmodule

`default_nettype wire

>>> hw/rtl/ncr_credit_mem.sv
// ----------------------------------------------------------------------------
// ncr_credit_mem: free channel counts per port and virtual network
// one write and one registered read port; unwritten slots read as zero
// ----------------------------------------------------------------------------
`default_nettype none

module ncr_credit_mem import ncr_pkg::*; #(
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_en_i,
  input  wire logic [AW-1:0]     wr_addr_i,
  input  wire logic [FREE_W-1:0] wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [AW-1:0]     rd_addr_i,
  output logic [FREE_W-1:0]      rd_data_o
);

  logic [FREE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  logic              rd_valid_q;
  logic [FREE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // slot never written reads as no free channels
  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

>>> hw/rtl/ncr_div.sv
// ----------------------------------------------------------------------------
// ncr_div: coordinate splitter
// two-lane restoring divider, one quotient bit per cycle, x = id % cols,
// y = id / cols for this router and the destination at once
// ----------------------------------------------------------------------------
`default_nettype none

module ncr_div import ncr_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [ID_W-1:0]  a_id_i,
  input  wire logic [ID_W-1:0]  b_id_i,
  input  wire logic [COL_W-1:0] cols_i,
  output logic                  done_o,
  output coord_t                a_o,
  output coord_t                b_o
);

  localparam int CNT_W = $clog2(ID_W);

  logic [COL_W-1:0] divisor_q;
  logic [ID_W-1:0]  a_quo_q, b_quo_q;
  logic [ID_W-1:0]  a_rem_q, b_rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [COL_W-1:0] a_trial, b_trial;
  logic             a_ge, b_ge;

  assign a_trial = {a_rem_q, a_quo_q[ID_W-1]};
  assign b_trial = {b_rem_q, b_quo_q[ID_W-1]};
  assign a_ge    = a_trial >= divisor_q;
  assign b_ge    = b_trial >= divisor_q;

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // zero columns behaves as a single column
      divisor_q <= (cols_i == '0) ? COL_W'(1) : cols_i;
      a_quo_q   <= a_id_i;
      b_quo_q   <= b_id_i;
      a_rem_q   <= '0;
      b_rem_q   <= '0;
    end else if (busy_q) begin
      a_quo_q <= {a_quo_q[ID_W-2:0], a_ge};
      b_quo_q <= {b_quo_q[ID_W-2:0], b_ge};
      a_rem_q <= a_ge ? ID_W'(a_trial - divisor_q) : ID_W'(a_trial);
      b_rem_q <= b_ge ? ID_W'(b_trial - divisor_q) : ID_W'(b_trial);
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(ID_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign a_o    = '{x: a_rem_q, y: a_quo_q};
  assign b_o    = '{x: b_rem_q, y: b_quo_q};

endmodule

`default_nettype wire

>>> hw/rtl/noc_route_compute_core.sv
// ----------------------------------------------------------------------------
// noc_route_compute_core: output port selection of a mesh router
// route table lookup with weight and free channel tie break, or xy,
// random, adaptive random, west-first and adaptive west-first mesh routing
// ----------------------------------------------------------------------------
// table writes, count updates and no-ops strobe done in the cycle after start
// table lookups read one entry per cycle, then strobe once the last entry is compared
// mesh routes: operand load, divider steps (one per quotient bit), port pick
// one item at a time; the next start is taken in the result cycle, so writes run
// one per cycle, while lookups and mesh routes hold busy until their result
// reset clears valid flags and free counts and restores config; the receiver cannot stall
`default_nettype none

module noc_route_compute_core import ncr_pkg::*; #(
  parameter int TABLE_DEPTH = 8,
  parameter int NUM_VNETS   = 4,
  parameter int DEST_WIDTH  = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // command side
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            op_i,
  input  wire logic [1:0]            vnet_i,
  input  wire logic [ID_W-1:0]       dest_router_i,
  input  wire logic [MASK_W-1:0]     dest_mask_i,
  input  wire logic                  coin_i,
  input  wire logic [FREE_W-1:0]     free_east_i,
  input  wire logic [FREE_W-1:0]     free_west_i,
  input  wire logic [FREE_W-1:0]     free_north_i,
  input  wire logic [FREE_W-1:0]     free_south_i,
  input  wire logic [2:0]            port_index_i,
  input  wire logic [WEIGHT_W-1:0]   weight_i,
  input  wire logic [FREE_W-1:0]     free_count_i,
  // result side
  output logic                       done_o,
  output logic [PORT_W-1:0]          outport_o,
  output logic                       no_route_o
);

  localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FREE_DEPTH = TABLE_DEPTH * NUM_VNETS;
  localparam int FREE_AW    = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DIV  = 2'd2
  } state_e;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [2:0]        alg_q;
  logic [ID_W-1:0]   my_id_q;
  logic [COL_W-1:0]  cols_q;
  logic [PORT_W-1:0] east_q, west_q, north_q, south_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alg_q   <= ALG_TABLE;
      my_id_q <= '0;
      cols_q  <= COLS_RESET;
      east_q  <= EAST_RESET;
      west_q  <= WEST_RESET;
      north_q <= NORTH_RESET;
      south_q <= SOUTH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ALGORITHM: alg_q   <= cfg_data_i[2:0];
        CFG_MY_ID:     my_id_q <= cfg_data_i[ID_W-1:0];
        CFG_COLUMNS:   cols_q  <= cfg_data_i[COL_W-1:0];
        CFG_EAST:      east_q  <= cfg_data_i[PORT_W-1:0];
        CFG_WEST:      west_q  <= cfg_data_i[PORT_W-1:0];
        CFG_NORTH:     north_q <= cfg_data_i[PORT_W-1:0];
        CFG_SOUTH:     south_q <= cfg_data_i[PORT_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // command decode
  // --------------------------------------------------------------------------
  state_e state_q, state_d;
  logic   accept;
  logic   is_route;
  logic   idx_ok;
  logic   vnet_in_ok;
  logic   mesh_alg;
  logic   use_table;

  assign accept     = start && !busy;
  assign is_route   = op_i == OP_ROUTE;
  assign idx_ok     = int'(port_index_i) < TABLE_DEPTH;
  assign vnet_in_ok = int'(vnet_i) < NUM_VNETS;

  always_comb begin
    case (alg_q) inside
      ALG_XY, ALG_RANDOM, ALG_ADAPT_RANDOM, ALG_WEST_FIRST, ALG_ADAPT_WEST_FIRST:
        mesh_alg = 1'b1;
      default:
        mesh_alg = 1'b0;  // table mode, including unused codes
    endcase
  end

  // traffic for this router always goes through the table
  assign use_table = (dest_router_i == my_id_q) || !mesh_alg;

  // request payload held for the duration of a route
  logic [DEST_WIDTH-1:0] dmask_q;
  logic [1:0]            vnet_q;
  logic                  vnet_ok_q;
  logic                  coin_q;
  logic [FREE_W-1:0]     fe_q, fw_q, fn_q, fs_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dmask_q   <= dest_mask_i[DEST_WIDTH-1:0];
      vnet_q    <= vnet_i;
      vnet_ok_q <= vnet_in_ok;
      coin_q    <= coin_i;
      fe_q      <= free_east_i;
      fw_q      <= free_west_i;
      fn_q      <= free_north_i;
      fs_q      <= free_south_i;
    end
  end

  // --------------------------------------------------------------------------
  // route table and free count memories
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0]   ptr_q, ptr_d;
  logic               rt_wr_en;
  logic               cr_wr_en;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [1:0]         vnet_sel;
  logic [FREE_AW-1:0] cr_wr_addr;
  logic [FREE_AW-1:0] cr_rd_addr;
  logic               rt_valid;
  logic [DEST_WIDTH-1:0] rt_mask;
  logic [WEIGHT_W-1:0] rt_weight;
  logic [FREE_W-1:0]  cr_free;

  // writes land at the accept edge; reads are only issued by a lookup
  assign rt_wr_en = accept && (op_i == OP_WRITE) && idx_ok;
  assign cr_wr_en = accept && (op_i == OP_FREE) && idx_ok && vnet_in_ok;

  // entry 0 is read at accept, then one entry ahead of the compare each cycle
  assign rd_en   = (accept && is_route && use_table)
                || (state_q == S_SCAN && ptr_q != LAST_IDX);
  assign rd_addr = (state_q == S_IDLE) ? '0 : ptr_q + IDX_W'(1);

  assign vnet_sel   = (state_q == S_IDLE) ? vnet_i : vnet_q;
  assign cr_wr_addr = FREE_AW'(int'(port_index_i) * NUM_VNETS + int'(vnet_i));
  assign cr_rd_addr = FREE_AW'(int'(rd_addr) * NUM_VNETS + int'(vnet_sel));

  ncr_route_mem #(
    .DEPTH     (TABLE_DEPTH),
    .MASK_BITS (DEST_WIDTH)
  ) u_route_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (rt_wr_en),
    .wr_addr_i   (IDX_W'(port_index_i)),
    .wr_mask_i   (dest_mask_i[DEST_WIDTH-1:0]),
    .wr_weight_i (weight_i),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .rd_valid_o  (rt_valid),
    .rd_mask_o   (rt_mask),
    .rd_weight_o (rt_weight)
  );

  ncr_credit_mem #(
    .DEPTH (FREE_DEPTH)
  ) u_credit_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cr_wr_en),
    .wr_addr_i (cr_wr_addr),
    .wr_data_i (free_count_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (cr_rd_addr),
    .rd_data_o (cr_free)
  );

  // --------------------------------------------------------------------------
  // table scan compare: lowest weight, then most free channels, first on ties
  // --------------------------------------------------------------------------
  logic                found_q, found_d;
  logic [WEIGHT_W-1:0] best_w_q, best_w_d;
  logic [FREE_W-1:0]   best_f_q, best_f_d;
  logic [IDX_W-1:0]    best_idx_q, best_idx_d;
  logic                hit;
  logic [FREE_W-1:0]   cur_free;
  logic                take;

  assign hit      = rt_valid && (|(rt_mask & dmask_q));
  // virtual network outside the range sees no free channels anywhere
  assign cur_free = vnet_ok_q ? cr_free : '0;
  assign take     = hit && (!found_q || (rt_weight < best_w_q)
                    || ((rt_weight == best_w_q) && (cur_free > best_f_q)));

  // --------------------------------------------------------------------------
  // coordinate split and mesh routing
  // --------------------------------------------------------------------------
  logic        div_start;
  logic        div_done;
  coord_t      my_c, dst_c;
  logic        xpos, ypos;
  logic [PORT_W-1:0] xp, yp, mesh_port;
  logic [FREE_W-1:0] xf, yf;

  assign div_start = accept && is_route && !use_table;

  ncr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_id_i  (my_id_q),
    .b_id_i  (dest_router_i),
    .cols_i  (cols_q),
    .done_o  (div_done),
    .a_o     (my_c),
    .b_o     (dst_c)
  );

  assign xpos = dst_c.x >= my_c.x;
  assign ypos = dst_c.y >= my_c.y;
  assign xp   = xpos ? east_q : west_q;
  assign yp   = ypos ? north_q : south_q;
  assign xf   = xpos ? fe_q : fw_q;
  assign yf   = ypos ? fn_q : fs_q;

  always_comb begin
    if (dst_c.x == my_c.x) begin
      mesh_port = yp;
    end else if (dst_c.y == my_c.y || alg_q == ALG_XY) begin
      mesh_port = xp;
    end else begin
      case (alg_q)
        ALG_RANDOM: begin
          mesh_port = coin_q ? xp : yp;
        end
        ALG_ADAPT_RANDOM: begin
          if (xf > yf) begin
            mesh_port = xp;
          end else if (yf > xf) begin
            mesh_port = yp;
          end else begin
            mesh_port = coin_q ? xp : yp;
          end
        end
        ALG_WEST_FIRST: begin
          if (!xpos) begin
            mesh_port = west_q;
          end else begin
            mesh_port = coin_q ? east_q : yp;
          end
        end
        default: begin
          // adaptive west-first: west is forced, else compare east with y
          if (!xpos) begin
            mesh_port = west_q;
          end else if (fe_q > yf) begin
            mesh_port = east_q;
          end else if (yf > fe_q) begin
            mesh_port = yp;
          end else begin
            mesh_port = coin_q ? east_q : yp;
          end
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  logic              done_q, done_d;
  logic [PORT_W-1:0] outport_q, outport_d;
  logic              no_route_q, no_route_d;

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    found_d    = found_q;
    best_w_d   = best_w_q;
    best_f_d   = best_f_q;
    best_idx_d = best_idx_q;
    done_d     = 1'b0;
    outport_d  = outport_q;
    no_route_d = no_route_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (is_route) begin
            ptr_d   = '0;
            found_d = 1'b0;
            state_d = use_table ? S_SCAN : S_DIV;
          end else begin
            // writes, updates and no-ops answer at once
            done_d     = 1'b1;
            outport_d  = '0;
            no_route_d = 1'b0;
          end
        end
      end
      S_SCAN: begin
        if (take) begin
          found_d    = 1'b1;
          best_w_d   = rt_weight;
          best_f_d   = cur_free;
          best_idx_d = ptr_q;
        end
        ptr_d = ptr_q + IDX_W'(1);
        if (ptr_q == LAST_IDX) begin
          done_d     = 1'b1;
          outport_d  = found_d ? PORT_W'(best_idx_d) : '0;
          no_route_d = !found_d;
          state_d    = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          done_d     = 1'b1;
          outport_d  = mesh_port;
          no_route_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ptr_q      <= '0;
      found_q    <= 1'b0;
      best_w_q   <= '0;
      best_f_q   <= '0;
      best_idx_q <= '0;
      done_q     <= 1'b0;
      outport_q  <= '0;
      no_route_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      found_q    <= found_d;
      best_w_q   <= best_w_d;
      best_f_q   <= best_f_d;
      best_idx_q <= best_idx_d;
      done_q     <= done_d;
      outport_q  <= outport_d;
      no_route_q <= no_route_d;
    end
  end

  assign busy       = state_q != S_IDLE;
  assign done_o     = done_q;
  assign outport_o  = outport_q;
  assign no_route_o = no_route_q;

`ifndef SYNTHESIS
  // a route request always occupies the core past its accept cycle
  a_route_holds_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_route) |=> busy)
    else $error("route request accepted without going busy");

  // mesh result follows the divider finish and never flags a missing route
  a_mesh_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && div_done) |=> (done_o && !no_route_o))
    else $error("mesh route result missing or flagged as no route");

  // a missing route reports port zero
  a_no_route_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && no_route_o) |-> (outport_o == '0))
    else $error("no route reported with a nonzero port");

  // the divider only finishes for a mesh request in flight
  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside a mesh route");
`endif

endmodule

`default_nettype wire
